// File: rtl/aes_pkg.sv
`default_nettype none
package aes_pkg;

  localparam int BlockBytes = 16;
  localparam int KeyWordCount = 4;
  localparam int RoundKeyDepth = 30;
  localparam int RkAddrW = 5;
  localparam int RoundW = 4;
  localparam int CfgIdxW = 3;

  localparam logic [CfgIdxW-1:0] CFG_KEY_SIZE = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_KEY_W0 = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_KEY_W3 = 3'd4;

  localparam logic [1:0] KEY_128 = 2'd0;
  localparam logic [1:0] KEY_192 = 2'd1;

  // controller to datapath
  typedef struct packed {
    logic capture;   // take the block at the input beat
    logic load;      // add first round key
    logic round;     // run one cipher round
    logic last;      // final round (no mix columns)
    logic dec;       // inverse cipher
    logic ke_start;  // begin key expansion
    logic ke_step;   // one expanded word
  } aes_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic ke_done;
  } aes_sts_t;

  function automatic logic [7:0] xt(input logic [7:0] a);
    xt = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    logic [7:0] x;
    p = 8'h00;
    x = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p = p ^ x;
      x = xt(x);
    end
    gmul = p;
  endfunction

  function automatic logic [7:0] ginv(input logic [7:0] x);
    logic [7:0] p;
    logic [7:0] r;
    p = x;
    r = 8'h01;
    for (int i = 1; i < 8; i++) begin
      p = gmul(p, p);
      r = gmul(r, p);
    end
    ginv = r;
  endfunction

  function automatic logic [7:0] rl8(input logic [7:0] v, input int n);
    rl8 = (v << n) | (v >> (8 - n));
  endfunction

  // S-box tables, built at elaboration from the field inverse
  function automatic logic [7:0] sbox_calc(input logic [7:0] x);
    logic [7:0] y;
    y = ginv(x);
    sbox_calc = y ^ rl8(y, 1) ^ rl8(y, 2) ^ rl8(y, 3) ^ rl8(y, 4) ^ 8'h63;
  endfunction

  function automatic logic [7:0] isbox_calc(input logic [7:0] s);
    isbox_calc = ginv(rl8(s, 1) ^ rl8(s, 3) ^ rl8(s, 6) ^ 8'h05);
  endfunction

  typedef logic [7:0] sbox_tab_t [256];

  function automatic sbox_tab_t mk_sbox(input logic inv);
    sbox_tab_t t;
    for (int i = 0; i < 256; i++)
      t[i] = inv ? isbox_calc(8'(i)) : sbox_calc(8'(i));
    mk_sbox = t;
  endfunction

  localparam sbox_tab_t SBOX = mk_sbox(1'b0);
  localparam sbox_tab_t ISBOX = mk_sbox(1'b1);

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

endpackage
`default_nettype wire

// File: rtl/aes_block_cipher.sv
// Flow: the accepted input beat is captured; key expansion runs first when the
// keys are not valid (first block after reset or after a write to the key size
// or a key word). The first round key is added, then one round runs per cycle
// for Nr = 10/12/14 rounds and out_tvalid rises. One block in flight: no input
// beat is taken until the result beat is. Reset (rst_n, synchronous, active
// low) clears the key registers and key-valid flag; the round key store has no reset.
`default_nettype none
module aes_block_cipher
  import aes_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         cfg_we,
  input  wire logic [CfgIdxW-1:0] cfg_addr,
  input  wire logic [63:0]  cfg_wdata,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [8*BlockBytes-1:0] in_tdata, // [63:0] block_high, [127:64] block_low
  input  wire logic         in_tuser,   // req_type
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [8*BlockBytes-1:0] out_tdata  // [63:0] result_high, [127:64] result_low
);

  logic [1:0]   key_size_r;
  logic [63:0]  key_r [KeyWordCount];
  aes_cmd_t     cmd;
  aes_sts_t     sts;
  logic [3:0]   rnd;
  logic [127:0] st;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_size_r <= KEY_128;
      for (int i = 0; i < KeyWordCount; i++) key_r[i] <= '0;
    end else if (cfg_we) begin
      if (cfg_addr == CFG_KEY_SIZE) key_size_r <= cfg_wdata[1:0];
      else if (cfg_addr >= CFG_KEY_W0 && cfg_addr <= CFG_KEY_W3)
        key_r[2'(cfg_addr - CFG_KEY_W0)] <= cfg_wdata;
    end
  end

  aes_ctrl u_ctrl (
    .clk, .rst_n,
    .cfg_we, .cfg_idx(cfg_addr),
    .key_size(key_size_r),
    .in_valid(in_tvalid), .in_dec(in_tuser), .in_ready(in_tready),
    .out_valid(out_tvalid), .out_ready(out_tready),
    .sts, .cmd, .rnd
  );

  aes_datapath u_dp (
    .clk, .rst_n, .cmd, .rnd,
    .key_size(key_size_r),
    .key({key_r[0], key_r[1], key_r[2], key_r[3]}),
    .blk_in({in_tdata[63:0], in_tdata[8*BlockBytes-1:64]}),
    .sts, .state(st)
  );

  assign out_tdata = {st[63:0], st[127:64]};

endmodule
`default_nettype wire

// File: rtl/aes_datapath.sv
`default_nettype none
module aes_datapath
  import aes_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire aes_cmd_t     cmd,
  input  wire logic [3:0]   rnd,        // round key number wanted next cycle
  input  wire logic [1:0]   key_size,
  input  wire logic [255:0] key,
  input  wire logic [127:0] blk_in,
  output aes_sts_t          sts,
  output logic [127:0]      state
);

  logic [127:0] state_r, state_nxt;
  logic [63:0]  rk_mem [RoundKeyDepth];
  logic [63:0]  rk_hi_r, rk_lo_r;

  // key expansion: sliding window of the last eight words
  logic [31:0] win_r [8];
  logic [31:0] win_nxt [8];
  logic [2:0]  ph_r, ph_nxt;          // word index mod nk
  logic [7:0]  rcon_r, rcon_nxt;
  logic [31:0] pair_r;                // even word held until its odd mate
  logic [3:0]  nk;
  logic [5:0]  total;
  logic [31:0] t_w, new_w, prev_w, back_w;
  logic        ke_busy_r;
  logic [5:0]  wr_i_r;                // next word index to store
  logic        ke_gen;                // window produces a stored word

  always_comb begin
    case (key_size)
      KEY_128: begin nk = 4'd4; total = 6'd44; end
      KEY_192: begin nk = 4'd6; total = 6'd52; end
      default: begin nk = 4'd8; total = 6'd60; end
    endcase
  end

  // window: win[0] newest; w[i-nk] at win[nk-1]
  assign prev_w = win_r[0];
  assign back_w = win_r[nk[2:0] - 3'd1];

  // generated words start once the key words are stored
  assign ke_gen = cmd.ke_step && ke_busy_r && (wr_i_r >= 6'(nk));

  always_comb begin
    t_w = prev_w;
    if (ph_r == 3'd0)
      t_w = sub_word({prev_w[23:0], prev_w[31:24]}) ^ {rcon_r, 24'h0};
    else if (nk == 4'd8 && ph_r == 3'd4)
      t_w = sub_word(prev_w);
    new_w = back_w ^ t_w;
  end

  always_comb begin
    for (int i = 0; i < 8; i++) win_nxt[i] = win_r[i];
    ph_nxt   = ph_r;
    rcon_nxt = rcon_r;
    if (cmd.ke_start) begin
      // preload key words, newest at win[0]
      for (int i = 0; i < 8; i++)
        win_nxt[i] = (i < nk) ? key[255 - 32*(nk - 1 - i) -: 32] : 32'h0;
      ph_nxt   = 3'd0;
      rcon_nxt = 8'h01;
    end else if (ke_gen) begin
      for (int i = 7; i > 0; i--) win_nxt[i] = win_r[i-1];
      win_nxt[0] = new_w;
      ph_nxt = (ph_r == nk[2:0] - 3'd1 || (nk == 4'd8 && ph_r == 3'd7)) ? 3'd0
               : ph_r + 3'd1;
      if (ph_r == 3'd0) rcon_nxt = xt(rcon_r);
    end
  end

  // key words from index 0 are also written; walk them through the same path
  logic [31:0] store_w;
  logic        store_v;
  always_comb begin
    store_v = 1'b0;
    store_w = new_w;
    if (ke_busy_r) begin
      if (wr_i_r < 6'(nk)) begin
        store_v = 1'b1;
        store_w = key[255 - 32*wr_i_r[2:0] -: 32];
      end else if (ke_gen) begin
        store_v = 1'b1;
      end
    end
  end

  assign sts.ke_done = ke_busy_r && store_v && (wr_i_r == total - 6'd1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ke_busy_r <= 1'b0;
      wr_i_r    <= '0;
    end else if (cmd.ke_start) begin
      ke_busy_r <= 1'b1;
      wr_i_r    <= '0;
    end else if (store_v) begin
      wr_i_r <= wr_i_r + 6'd1;
      if (sts.ke_done) ke_busy_r <= 1'b0;
    end
    for (int i = 0; i < 8; i++) win_r[i] <= win_nxt[i];
    ph_r   <= ph_nxt;
    rcon_r <= rcon_nxt;
    if (store_v && !wr_i_r[0]) pair_r <= store_w;
    if (store_v && wr_i_r[0]) rk_mem[wr_i_r[5:1]] <= {pair_r, store_w};
  end

  // round key read, registered; the address is given in the cycle before its use
  always_ff @(posedge clk) begin
    rk_hi_r <= rk_mem[{rnd, 1'b0}];
    rk_lo_r <= rk_mem[{rnd, 1'b1}];
  end

  // cipher round; byte i at bits 127-8i
  logic [7:0] s [16];
  logic [7:0] sh [16];
  logic [7:0] mx [16];
  logic [7:0] sb [16];
  always_comb begin
    for (int i = 0; i < 16; i++) s[i] = state_r[127 - 8*i -: 8];
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        if (cmd.dec) sh[c*4 + r] = ISBOX[s[((c + 4 - r) % 4)*4 + r]];
        else         sh[c*4 + r] = SBOX[s[((c + r) % 4)*4 + r]];
    // decrypt: key add happens before inverse mix columns
    for (int i = 0; i < 16; i++)
      sb[i] = cmd.dec ? sh[i] ^ (i < 8 ? rk_hi_r[63 - 8*i -: 8] : rk_lo_r[63 - 8*(i-8) -: 8])
                      : sh[i];
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        if (cmd.last)
          mx[c*4 + r] = sb[c*4 + r];
        else if (cmd.dec)
          mx[c*4 + r] = gmul(8'd14, sb[c*4 + r]) ^ gmul(8'd11, sb[c*4 + (r+1)%4])
                      ^ gmul(8'd13, sb[c*4 + (r+2)%4]) ^ gmul(8'd9, sb[c*4 + (r+3)%4]);
        else
          mx[c*4 + r] = xt(sb[c*4 + r]) ^ xt(sb[c*4 + (r+1)%4]) ^ sb[c*4 + (r+1)%4]
                      ^ sb[c*4 + (r+2)%4] ^ sb[c*4 + (r+3)%4];
  end

  always_comb begin
    state_nxt = state_r;
    if (cmd.capture) begin
      state_nxt = blk_in;
    end else if (cmd.load) begin
      state_nxt = state_r ^ {rk_hi_r, rk_lo_r};
    end else if (cmd.round) begin
      for (int i = 0; i < 16; i++) state_nxt[127 - 8*i -: 8] = mx[i];
      if (!cmd.dec) state_nxt = state_nxt ^ {rk_hi_r, rk_lo_r};
    end
  end

  always_ff @(posedge clk) begin
    state_r <= state_nxt;
  end

  assign state = state_r;

endmodule
`default_nettype wire

// File: rtl/aes_ctrl.sv
`default_nettype none
module aes_ctrl
  import aes_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic [CfgIdxW-1:0] cfg_idx,
  input  wire logic [1:0] key_size,
  input  wire logic       in_valid,
  input  wire logic       in_dec,
  output logic            in_ready,
  output logic            out_valid,
  input  wire logic       out_ready,
  input  wire aes_sts_t   sts,
  output aes_cmd_t        cmd,
  output logic [3:0]      rnd
);

  typedef enum logic [2:0] {S_IDLE, S_KEXP, S_KEND, S_LOAD, S_RUN, S_OUT} st_t;

  st_t        st_r, st_nxt;
  logic       ready_keys_r, ready_keys_nxt;
  logic       dec_r, dec_nxt;
  logic [3:0] rnd_r, rnd_nxt;
  logic [3:0] nr;

  assign nr = (key_size == KEY_128) ? 4'd10 : (key_size == KEY_192) ? 4'd12 : 4'd14;

  assign in_ready  = (st_r == S_IDLE);
  assign out_valid = (st_r == S_OUT);
  // round key number for the next cycle (store read is registered)
  assign rnd = (st_nxt == S_LOAD) ? (dec_nxt ? nr : 4'd0) : rnd_nxt;

  always_comb begin
    cmd = '0;
    cmd.dec = dec_r;
    case (st_r)
      S_KEXP: cmd.ke_step = 1'b1;
      S_LOAD: cmd.load = 1'b1;
      S_RUN: begin
        cmd.round = 1'b1;
        cmd.last  = dec_r ? (rnd_r == 4'd0) : (rnd_r == nr);
      end
      default: ;
    endcase
    if (st_r == S_IDLE && in_valid) cmd.capture = 1'b1;
    if (st_r == S_IDLE && in_valid && !ready_keys_r) cmd.ke_start = 1'b1;
  end

  always_comb begin
    st_nxt = st_r;
    ready_keys_nxt = ready_keys_r;
    dec_nxt = dec_r;
    rnd_nxt = rnd_r;
    case (st_r)
      S_IDLE: if (in_valid) begin
        dec_nxt = in_dec;
        st_nxt  = ready_keys_r ? S_LOAD : S_KEXP;
      end
      S_KEXP: if (sts.ke_done) begin
        ready_keys_nxt = 1'b1;
        st_nxt = S_KEND;
      end
      // last round key pair lands in the store; read it next cycle
      S_KEND: st_nxt = S_LOAD;
      S_LOAD: begin
        rnd_nxt = dec_r ? nr - 4'd1 : 4'd1;
        st_nxt  = S_RUN;
      end
      S_RUN: begin
        if (cmd.last) st_nxt = S_OUT;
        else rnd_nxt = dec_r ? rnd_r - 4'd1 : rnd_r + 4'd1;
      end
      S_OUT: if (out_ready) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
    if (cfg_we && cfg_idx <= CFG_KEY_W3) ready_keys_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      ready_keys_r <= 1'b0;
      dec_r <= 1'b0;
      rnd_r <= '0;
    end else begin
      st_r <= st_nxt;
      ready_keys_r <= ready_keys_nxt;
      dec_r <= dec_nxt;
      rnd_r <= rnd_nxt;
    end
  end

endmodule
`default_nettype wire

// File: rtl/aes_block_cipher_chk.sv
`default_nettype none
module aes_block_cipher_chk (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_tvalid,
  input wire logic in_tready,
  input wire logic out_tvalid,
  input wire logic out_tready,
  input wire logic [127:0] out_tdata
);
  // output beat held while stalled
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)) else $error("out held");
  // one block at a time: no input while a result waits
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid)) else $error("ready with result pending");
  // an accepted block cannot produce a result on the next edge
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !out_tvalid) else $error("latency");
  // reset leaves no result pending
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_tvalid) else $error("reset");
endmodule

bind aes_block_cipher aes_block_cipher_chk u_chk (
  .clk, .rst_n, .in_tvalid, .in_tready, .out_tvalid, .out_tready, .out_tdata
);
`default_nettype wire
